### rtl/tmbm_pkg.sv
// Shared constants, types and register codes for the trimmed-mean battery monitor.
package tmbm_pkg;

	localparam int WIN_SAMPLES = 9;
	localparam int MID_POS = WIN_SAMPLES / 2;
	localparam int SAMPLE_W = 12;
	localparam int SUM_W = SAMPLE_W + 2;
	localparam int GAIN_W = 18;
	localparam int MV_W = 16;
	localparam int GAIN_FRAC = 16;

	// floor(x / 3) == (x * RECIP3) >> RECIP3_SH for every x below 2**SUM_W
	localparam int RECIP3_W = 16;
	localparam int RECIP3_SH = 17;
	localparam logic [RECIP3_W-1:0] RECIP3 = 16'd43691;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MV = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_RST = 18'd198498;
	localparam logic [MV_W-1:0] MIN_MV_RST = 16'd2500;
	localparam logic [MV_W-1:0] MAX_MV_RST = 16'd5000;

	// what one cell shows its right-hand neighbor
	typedef struct packed {
		logic vld;
		logic gt;
		logic [SAMPLE_W-1:0] val;
	} link_t;

endpackage

### rtl/tmbm_cell.sv
// One cell of the sorted insertion chain: holds one window entry.
module tmbm_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ins_en,
	input  logic                            clr,
	input  logic [tmbm_pkg::SAMPLE_W-1:0]   ins_val,
	input  tmbm_pkg::link_t                 left,
	output tmbm_pkg::link_t                 self_lnk,
	output logic [tmbm_pkg::SAMPLE_W-1:0]   nxt_val
);
	import tmbm_pkg::*;

	logic                vld_q;
	logic [SAMPLE_W-1:0] val_q;
	logic                gt;

	// empty cells count as larger than any sample
	assign gt = !vld_q || (val_q > ins_val);
	assign nxt_val = gt ? (left.gt ? left.val : ins_val) : val_q;
	assign self_lnk = '{vld: vld_q, gt: gt, val: val_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clr) begin
			vld_q <= 1'b0;
		end else if (ins_en) begin
			vld_q <= vld_q | left.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			val_q <= nxt_val;
		end
	end

endmodule

### rtl/tmbm_scale.sv
// Mean, gain multiply and limit check of the middle-sample sum, with output register.
module tmbm_scale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sum_valid,
	output logic                           sum_ready,
	input  logic [tmbm_pkg::SUM_W-1:0]     sum,
	input  logic [tmbm_pkg::GAIN_W-1:0]    gain_q16,
	input  logic [tmbm_pkg::MV_W-1:0]      min_valid_mv,
	input  logic [tmbm_pkg::MV_W-1:0]      max_valid_mv,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tmbm_pkg::MV_W-1:0]      battery_mv,
	output logic                           battery_present
);
	import tmbm_pkg::*;

	localparam int MPROD_W = SUM_W + RECIP3_W;
	localparam int GPROD_W = SAMPLE_W + GAIN_W;

	logic                v_s2, v_s3, out_v_q;
	logic [SAMPLE_W-1:0] mean_s2;
	logic [MV_W-1:0]     scaled_s3;
	logic [MV_W-1:0]     mv_q;
	logic                pres_q;
	logic                out_free, s3_free, s2_free;
	logic [MPROD_W-1:0]  mprod;
	logic [GPROD_W-1:0]  gprod;
	logic                in_range;

	assign out_free = !out_v_q || out_ready;
	assign s3_free = !v_s3 || out_free;
	assign s2_free = !v_s2 || s3_free;
	assign sum_ready = s2_free;

	assign mprod = MPROD_W'(sum) * MPROD_W'(RECIP3);
	assign gprod = GPROD_W'(mean_s2) * GPROD_W'(gain_q16);
	assign in_range = (scaled_s3 >= min_valid_mv) && (scaled_s3 <= max_valid_mv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s2_free) v_s2 <= sum_valid;
			if (s3_free) v_s3 <= v_s2;
			if (out_free) out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && sum_valid) begin
			mean_s2 <= mprod[RECIP3_SH +: SAMPLE_W];
		end
		if (s3_free && v_s2) begin
			// product stays below 2**30, so the bits above the fraction fit sixteen bits
			scaled_s3 <= MV_W'(gprod[GPROD_W-1:GAIN_FRAC]);
		end
		if (out_free && v_s3) begin
			mv_q <= in_range ? scaled_s3 : '0;
			pres_q <= in_range;
		end
	end

	assign out_valid = out_v_q;
	assign battery_mv = mv_q;
	assign battery_present = pres_q;

endmodule

### rtl/trimmed_mean_battery_monitor.sv
// Top level of the trimmed-mean battery monitor: insertion chain, sum stage, registers.
// Usage: every sample transfer is inserted into a chain of nine cells that keeps the
// window in ascending order; a new sample can be taken every clock cycle. The transfer
// that brings the ninth sample empties the window and starts the result: the three
// middle entries are summed, the sum is divided by three (reciprocal multiply), scaled
// by gain_q16 and checked against min_valid_mv..max_valid_mv inclusive. The result is
// offered on the output channel; out of range gives battery_mv = 0 and
// battery_present = 0. The sum register, two arithmetic stages and the output register
// form an elastic pipeline; sample transfers pause only while the sum register is held
// by a stalled output side. Registers are written through the configuration channel,
// which is always ready; writes to an unused index are ignored.
module trimmed_mean_battery_monitor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tmbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmbm_pkg::GAIN_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tmbm_pkg::SAMPLE_W-1:0]    sample_mv,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tmbm_pkg::MV_W-1:0]        battery_mv,
	output logic                             battery_present
);
	import tmbm_pkg::*;

	// configuration registers
	logic [GAIN_W-1:0] gain_q;
	logic [MV_W-1:0]   min_mv_q;
	logic [MV_W-1:0]   max_mv_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RST;
			min_mv_q <= MIN_MV_RST;
			max_mv_q <= MAX_MV_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GAIN:   gain_q <= cfg_data;
				CFG_MIN_MV: min_mv_q <= cfg_data[MV_W-1:0];
				CFG_MAX_MV: max_mv_q <= cfg_data[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// insertion chain; lnk[i] is what feeds cell i from its left
	link_t               lnk [WIN_SAMPLES+1];
	logic [SAMPLE_W-1:0] nxt [WIN_SAMPLES];
	logic [WIN_SAMPLES-1:0] vld_vec;
	logic                in_xfer;
	logic                fills;

	assign lnk[0] = '{vld: 1'b1, gt: 1'b0, val: '0};
	assign in_xfer = in_valid && in_ready;
	// eight held entries: this sample completes the window
	assign fills = lnk[WIN_SAMPLES-1].vld;

	for (genvar i = 0; i < WIN_SAMPLES; i++) begin : g_cell
		tmbm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ins_en   (in_xfer),
			.clr      (in_xfer && fills),
			.ins_val  (sample_mv),
			.left     (lnk[i]),
			.self_lnk (lnk[i+1]),
			.nxt_val  (nxt[i])
		);
		assign vld_vec[i] = lnk[i+1].vld;
	end

	// middle-sum stage, loaded from the chain's next-state values
	logic             s1_v;
	logic [SUM_W-1:0] sum_s1;
	logic             scale_rdy;

	assign in_ready = !s1_v || scale_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_xfer && fills) begin
			s1_v <= 1'b1;
		end else if (scale_rdy) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && fills) begin
			sum_s1 <= SUM_W'(nxt[MID_POS-1]) + SUM_W'(nxt[MID_POS]) + SUM_W'(nxt[MID_POS+1]);
		end
	end

	tmbm_scale u_scale (
		.clk             (clk),
		.arst_n          (arst_n),
		.sum_valid       (s1_v),
		.sum_ready       (scale_rdy),
		.sum             (sum_s1),
		.gain_q16        (gain_q),
		.min_valid_mv    (min_mv_q),
		.max_valid_mv    (max_mv_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.battery_mv      (battery_mv),
		.battery_present (battery_present)
	);

	// held entries stay ascending
	logic order_ok;

	always_comb begin
		order_ok = 1'b1;
		for (int i = 1; i < WIN_SAMPLES; i++) begin
			if (lnk[i+1].vld && (lnk[i].val > lnk[i+1].val)) order_ok = 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_vec + WIN_SAMPLES'(1)) & vld_vec) == '0)
		else $error("window valid bits are not a prefix");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n) order_ok)
		else $error("window lost ascending order");

	a_empty_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && fills) |=> (vld_vec == '0) && s1_v)
		else $error("window not emptied after completing transfer");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && !scale_rdy) |=> (s1_v && $stable(sum_s1)))
		else $error("middle sum changed while stalled");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for the trimmed-mean battery monitor.
module tb_top;
	import tmbm_pkg::*;

	// Index that no register answers to; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam int ITEMS_TARGET = 450;
	localparam int CYCLE_LIMIT = 200000;
	// Settling margin after the last pending reading has been seen.
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_GUARD = 3000;
	localparam int LONG_HOLD = 150;

	typedef struct packed {
		logic [MV_W-1:0] mv;
		logic present;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [SAMPLE_W-1:0] sample_mv = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [MV_W-1:0] battery_mv;
	logic battery_present;

	// Shadow copy of the block: registers, sorted window, fill count.
	logic [GAIN_W-1:0] gain_model = GAIN_RST;
	logic [MV_W-1:0] min_mv_model = MIN_MV_RST;
	logic [MV_W-1:0] max_mv_model = MAX_MV_RST;
	logic [SAMPLE_W-1:0] window_model [WIN_SAMPLES] = '{default: '0};
	int window_fill = 0;

	reading_t pending_readings [$];
	reading_t head_reading;

	int mismatch_count = 0;
	int samples_sent = 0;
	int samples_taken = 0;
	int readings_seen = 0;
	int present_seen = 0;
	int writes_done = 0;
	int input_stall_cycles = 0;
	int cycle_count = 0;

	// Idling knobs and the long receiver hold request.
	bit src_gaps_on = 1'b1;
	bit sink_gaps_on = 1'b1;
	int sink_hold_req = 0;
	int sink_hold_left = 0;
	int sink_wait = 0;

	trimmed_mean_battery_monitor u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_mv(sample_mv),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.battery_mv(battery_mv),
		.battery_present(battery_present)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Mean times Q16 gain, truncated to whole millivolts.
	function automatic logic [MV_W-1:0] scale_of(input logic [SAMPLE_W-1:0] mean);
		logic [SAMPLE_W+GAIN_W-1:0] prod;
		prod = (SAMPLE_W+GAIN_W)'(mean) * (SAMPLE_W+GAIN_W)'(gain_model);
		return MV_W'(prod >> GAIN_FRAC);
	endfunction

	// Insert one sample after any equal entries; on a full window queue the
	// trimmed-mean reading and start over empty.
	function automatic void absorb_sample(input logic [SAMPLE_W-1:0] v);
		int pos;
		logic [SUM_W-1:0] mid_sum;
		logic [SAMPLE_W-1:0] mean;
		logic [MV_W-1:0] scaled;
		reading_t r;
		pos = window_fill;
		while (pos > 0 && window_model[pos-1] > v) begin
			window_model[pos] = window_model[pos-1];
			pos--;
		end
		window_model[pos] = v;
		window_fill++;
		if (window_fill == WIN_SAMPLES) begin
			mid_sum = SUM_W'(window_model[MID_POS-1]) + SUM_W'(window_model[MID_POS])
				+ SUM_W'(window_model[MID_POS+1]);
			mean = SAMPLE_W'(mid_sum / 3);
			scaled = scale_of(mean);
			// inverted limits fall out here: no value satisfies both bounds
			r.present = (scaled >= min_mv_model) && (scaled <= max_mv_model);
			r.mv = r.present ? scaled : '0;
			pending_readings.push_back(r);
			window_model = '{default: '0};
			window_fill = 0;
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Scoreboard: compare outputs first, then fold in this edge's transfers.
	// All values are the ones sampled at the edge (drivers use NBAs).
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				readings_seen++;
				if (battery_present)
					present_seen++;
				if (pending_readings.size() == 0) begin
					report_mismatch("reading with nothing pending, battery_mv", battery_mv, 0);
				end else begin
					head_reading = pending_readings.pop_front();
					if (battery_mv !== head_reading.mv)
						report_mismatch("battery_mv", battery_mv, head_reading.mv);
					if (battery_present !== head_reading.present)
						report_mismatch("battery_present", battery_present, head_reading.present);
				end
			end
			if (in_valid && !in_ready)
				input_stall_cycles++;
			if (in_valid && in_ready) begin
				samples_taken++;
				absorb_sample(sample_mv);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GAIN: gain_model = cfg_data;
					CFG_MIN_MV: min_mv_model = cfg_data[MV_W-1:0];
					CFG_MAX_MV: max_mv_model = cfg_data[MV_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random wait per reading, plus an optional long hold
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (sink_hold_req != 0) begin
			sink_hold_left = sink_hold_req;
			sink_hold_req = 0;
			sink_wait = 0;
		end
		if (sink_hold_left != 0) begin
			sink_hold_left--;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			sink_wait = sink_gaps_on ? $urandom_range(0, 5) : 0;
			out_ready <= (sink_wait == 0);
		end else if (sink_wait != 0) begin
			sink_wait--;
			out_ready <= (sink_wait == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// One sample transfer. Valid is left high on return; anything that is not
	// another sample goes through wait_drained first, which lowers it.
	task automatic push_sample(input logic [SAMPLE_W-1:0] v);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_mv <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		samples_sent++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		writes_done++;
	endtask

	// Stop sending, wait out every pending reading, then let the pipe settle.
	task automatic wait_drained();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending_readings.size() != 0 && guard < DRAIN_GUARD);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A window whose three middle entries are a, b, c: lows at or below the
	// smallest, highs at or above the largest, then shuffled.
	task automatic send_framed_window(input int a, input int b, input int c);
		logic [SAMPLE_W-1:0] batch [WIN_SAMPLES];
		logic [SAMPLE_W-1:0] tmp;
		int lo, hi, j;
		lo = (a < b) ? a : b;
		lo = (lo < c) ? lo : c;
		hi = (a > b) ? a : b;
		hi = (hi > c) ? hi : c;
		batch[0] = SAMPLE_W'(a);
		batch[1] = SAMPLE_W'(b);
		batch[2] = SAMPLE_W'(c);
		for (int i = 3; i < 3 + MID_POS - 1; i++)
			batch[i] = SAMPLE_W'($urandom_range(0, lo));
		for (int i = 3 + MID_POS - 1; i < WIN_SAMPLES; i++)
			batch[i] = SAMPLE_W'($urandom_range(hi, 4095));
		for (int i = WIN_SAMPLES - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = batch[i];
			batch[i] = batch[j];
			batch[j] = tmp;
		end
		for (int i = 0; i < WIN_SAMPLES; i++)
			push_sample(batch[i]);
	endtask

	function automatic int clamp_sample(input int v);
		return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset register values. First window arrives in descending order, so
	// every insertion shifts the whole window; it spans 0 to full scale and
	// lands just inside the default limits. Second is nine equal full-scale
	// samples, which scale above the default maximum.
	task automatic test_reset_registers();
		int descending [WIN_SAMPLES] = '{4095, 3000, 2000, 1700, 1650, 1600, 1000, 500, 0};
		for (int i = 0; i < WIN_SAMPLES; i++)
			push_sample(SAMPLE_W'(descending[i]));
		for (int i = 0; i < WIN_SAMPLES; i++)
			push_sample(12'hFFF);
	endtask

	// Largest gain with the widest limits, written with stray high data bits
	// that the 16-bit limits must drop; a write to the unused index must be
	// ignored. Full-scale window gives the largest possible reading.
	task automatic test_register_extremes();
		wait_drained();
		write_register(CFG_GAIN, 18'h3FFFF);
		write_register(CFG_MIN_MV, 18'h30000);
		write_register(CFG_MAX_MV, 18'h3FFFF);
		write_register(CFG_UNUSED, GAIN_W'($urandom));
		for (int i = 0; i < WIN_SAMPLES; i++)
			push_sample(12'hFFF);
	endtask

	// Limits set to exactly the readings of means c and c+1: c-1 falls below,
	// c and c+1 sit on the bounds, c+2 falls above. Then the same bounds
	// swapped, so nothing can be present.
	task automatic test_limit_edges();
		int c;
		logic [MV_W-1:0] lo_mv, hi_mv;
		for (int round = 0; round < 2; round++) begin
			wait_drained();
			write_register(CFG_GAIN, (round == 0) ? GAIN_RST : GAIN_W'($urandom_range(65536, 262143)));
			c = $urandom_range(1, 4093);
			lo_mv = scale_of(SAMPLE_W'(c));
			hi_mv = scale_of(SAMPLE_W'(c + 1));
			write_register(CFG_MIN_MV, GAIN_W'(lo_mv));
			write_register(CFG_MAX_MV, GAIN_W'(hi_mv));
			for (int k = -1; k <= 2; k++)
				send_framed_window(c + k, c + k, c + k);
			wait_drained();
			write_register(CFG_MIN_MV, GAIN_W'(hi_mv));
			write_register(CFG_MAX_MV, GAIN_W'(lo_mv));
			send_framed_window(c, c, c);
			send_framed_window(c + 1, c, c + 1);
		end
	endtask

	// Receiver goes quiet for a long stretch while the sender streams full
	// windows back to back, so the result pipe fills and in_ready drops.
	task automatic test_backpressure();
		wait_drained();
		write_register(CFG_GAIN, GAIN_RST);
		write_register(CFG_MIN_MV, GAIN_W'(16'd0));
		write_register(CFG_MAX_MV, GAIN_W'(16'hFFFF));
		src_gaps_on = 1'b0;
		sink_hold_req = LONG_HOLD;
		repeat (6)
			send_framed_window($urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095));
		wait_drained();
		src_gaps_on = 1'b1;
	endtask

	// Random phases: fresh register set per phase, mostly well-formed windows
	// with random middles, some fully random windows and some stray samples
	// that shift the window alignment across phase boundaries.
	task automatic test_random_phases();
		int pick, mode, m, lo_v, hi_v;
		while (samples_sent < ITEMS_TARGET) begin
			wait_drained();
			mode = $urandom_range(0, 5);
			case (mode)
				0: begin
					write_register(CFG_GAIN, GAIN_RST);
					write_register(CFG_MIN_MV, GAIN_W'(MIN_MV_RST));
					write_register(CFG_MAX_MV, GAIN_W'(MAX_MV_RST));
				end
				1: begin
					lo_v = $urandom_range(0, 8000);
					hi_v = lo_v + $urandom_range(0, 8000);
					write_register(CFG_GAIN, GAIN_W'($urandom));
					write_register(CFG_MIN_MV, GAIN_W'(lo_v));
					write_register(CFG_MAX_MV, GAIN_W'(hi_v));
				end
				2: begin
					// zero gain: every reading is 0 mV
					write_register(CFG_GAIN, '0);
					write_register(CFG_MIN_MV, GAIN_W'(16'd0));
					write_register(CFG_MAX_MV, GAIN_W'($urandom_range(0, 65535)));
				end
				3: begin
					hi_v = $urandom_range(0, 12000);
					lo_v = hi_v + $urandom_range(1, 4000);
					write_register(CFG_GAIN, GAIN_W'($urandom_range(150000, 262143)));
					write_register(CFG_MIN_MV, GAIN_W'(lo_v));
					write_register(CFG_MAX_MV, GAIN_W'(hi_v));
				end
				4: begin
					write_register(CFG_GAIN, GAIN_W'($urandom));
					write_register(CFG_MIN_MV, {2'($urandom_range(0, 3)), 16'd0});
					write_register(CFG_MAX_MV, {2'($urandom_range(0, 3)), 16'hFFFF});
				end
				default: begin
					write_register(CFG_GAIN, GAIN_W'($urandom));
					write_register(CFG_MIN_MV, {2'($urandom_range(0, 3)), 16'($urandom)});
					write_register(CFG_MAX_MV, {2'($urandom_range(0, 3)), 16'($urandom)});
				end
			endcase
			src_gaps_on = ($urandom_range(0, 3) != 0);
			sink_gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 7)) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					m = $urandom_range(0, 4095);
					send_framed_window(clamp_sample(m + $urandom_range(0, 40) - 20),
						clamp_sample(m + $urandom_range(0, 40) - 20),
						clamp_sample(m + $urandom_range(0, 40) - 20));
				end else if (pick < 85) begin
					for (int i = 0; i < WIN_SAMPLES; i++)
						push_sample(SAMPLE_W'($urandom_range(0, 4095)));
				end else begin
					repeat ($urandom_range(1, 4))
						push_sample(SAMPLE_W'($urandom_range(0, 4095)));
				end
			end
		end
		src_gaps_on = 1'b1;
		sink_gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_registers();
		test_register_extremes();
		test_limit_edges();
		test_backpressure();
		test_random_phases();

		wait_drained();
		if (pending_readings.size() != 0)
			report_mismatch("readings never delivered", 0, pending_readings.size());

		$display("Run covered %0d samples sent (%0d taken), %0d readings, %0d in range,",
			samples_sent, samples_taken, readings_seen, present_seen);
		$display("  %0d register writes and %0d cycles of input stall.",
			writes_done, input_stall_cycles);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: any hang ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### trimmed_mean_battery_monitor.f
rtl/tmbm_pkg.sv
rtl/tmbm_cell.sv
rtl/tmbm_scale.sv
rtl/trimmed_mean_battery_monitor.sv
verif/tb_top.sv
